// ===== rtl/core/swrc_pkg.sv =====
// ----------------------------------------------------------------------------
// swrc_pkg: shared types and constants for the stop-and-wait receiver
// Packet type codes, verdict codes, the queued command word and the
// byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package swrc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PAYLOAD_DEFAULT = 1024;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // CRC-32 (reflected)
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Packet types carried in a header word
  localparam logic [7:0] PTYPE_UPLOAD = 8'd1;
  localparam logic [7:0] PTYPE_DATA   = 8'd3;
  localparam logic [7:0] PTYPE_END    = 8'd5;

  // Input word modes
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;

  // Verdict codes
  typedef logic [2:0] verdict_t;
  localparam verdict_t V_ACCEPTED   = 3'd0;
  localparam verdict_t V_CRC_BAD    = 3'd1;
  localparam verdict_t V_OOO_REACK  = 3'd2;
  localparam verdict_t V_OOO_SILENT = 3'd3;
  localparam verdict_t V_END        = 3'd4;
  localparam verdict_t V_TOO_LONG   = 3'd5;
  localparam verdict_t V_REQUEST    = 3'd6;

  // Command kinds handed from the classifier to the execution side
  typedef logic [2:0] cmd_kind_t;
  localparam cmd_kind_t CMD_BYTE     = 3'd0;
  localparam cmd_kind_t CMD_UPLOAD   = 3'd1;
  localparam cmd_kind_t CMD_END      = 3'd2;
  localparam cmd_kind_t CMD_DATA     = 3'd3;
  localparam cmd_kind_t CMD_TOO_LONG = 3'd4;

  // One classified word
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] crc;
    logic [7:0]  data;
  } cmd_t;

  // One byte through the reflected CRC-32, bit at a time (unrolled)
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  byte_in);
    logic [31:0] c;
    c = crc_in ^ {24'd0, byte_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/swrc_front.sv =====
// ----------------------------------------------------------------------------
// swrc_front: input classifier
// Decodes each input word into a command; unknown header types are
// consumed and dropped here. Oversize data headers are flagged.
// ----------------------------------------------------------------------------
module swrc_front
  import swrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_packet_type,
  input  logic [31:0] in_sequence_req,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_sent_crc,
  input  logic [7:0]  in_data_byte,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic known;

  // Accept whenever the queue has room; dropped words still go through
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && known;

  // Classify
  always_comb begin
    known    = 1'b1;
    cmd.kind = CMD_BYTE;
    cmd.seq  = in_sequence_req;
    cmd.len  = in_payload_length;
    cmd.crc  = in_sent_crc;
    cmd.data = in_data_byte;
    if (in_mode == MODE_BYTE) begin
      cmd.kind = CMD_BYTE;
    end else begin
      unique case (in_packet_type)
        PTYPE_UPLOAD: cmd.kind = CMD_UPLOAD;
        PTYPE_END:    cmd.kind = CMD_END;
        PTYPE_DATA:   cmd.kind = (in_payload_length > MaxLen) ? CMD_TOO_LONG : CMD_DATA;
        default:      known    = 1'b0;
      endcase
    end
  end

endmodule

// ===== rtl/core/swrc_fifo.sv =====
// ----------------------------------------------------------------------------
// swrc_fifo: command queue
// Small register FIFO between the classifier and the execution side.
// ----------------------------------------------------------------------------
module swrc_fifo
  import swrc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != Full);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/core/swrc_back.sv =====
// ----------------------------------------------------------------------------
// swrc_back: packet execution
// Holds the receiver state, runs the CRC per byte, decides the verdict
// and keeps the result word in an output register.
// ----------------------------------------------------------------------------
module swrc_back
  import swrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic        out_ack_valid,
  output logic [31:0] out_ack_sequence,
  output logic [31:0] out_computed_crc
);

  logic [31:0] expected_r, expected_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [31:0] held_seq_r, held_seq_nxt;
  logic [15:0] held_len_r, held_len_nxt;
  logic [31:0] held_crc_r, held_crc_nxt;
  logic        collecting_r, collecting_nxt;

  logic        out_valid_r, out_valid_nxt;
  verdict_t    verdict_r, verdict_nxt;
  logic        ack_r, ack_nxt;
  logic [31:0] ack_seq_r, ack_seq_nxt;
  logic [31:0] ccrc_r, ccrc_nxt;

  logic        take, emit, finish;
  logic [31:0] crc_upd, fin_crc, fin_held_crc, fin_seq;

  // Take a command whenever the output register is free or draining
  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign crc_upd   = crc_byte(crc_r, cmd.data);

  // Command execution
  always_comb begin
    expected_nxt   = expected_r;
    crc_nxt        = crc_r;
    bytes_nxt      = bytes_r;
    held_seq_nxt   = held_seq_r;
    held_len_nxt   = held_len_r;
    held_crc_nxt   = held_crc_r;
    collecting_nxt = collecting_r;
    emit           = 1'b0;
    finish         = 1'b0;
    verdict_nxt    = verdict_r;
    ack_nxt        = 1'b0;
    ack_seq_nxt    = '0;
    ccrc_nxt       = '0;
    fin_crc        = ~crc_upd;
    fin_held_crc   = held_crc_r;
    fin_seq        = held_seq_r;

    if (take) begin
      unique case (cmd.kind)
        CMD_BYTE: begin
          if (collecting_r) begin
            crc_nxt   = crc_upd;
            bytes_nxt = bytes_r + 16'd1;
            if (bytes_nxt == held_len_r) finish = 1'b1;
          end
        end
        CMD_UPLOAD: begin
          collecting_nxt = 1'b0;
          expected_nxt   = '0;
          emit           = 1'b1;
          verdict_nxt    = V_REQUEST;
          ack_nxt        = 1'b1;
        end
        CMD_END: begin
          collecting_nxt = 1'b0;
          emit           = 1'b1;
          verdict_nxt    = V_END;
          ack_nxt        = 1'b1;
          ack_seq_nxt    = cmd.seq;
        end
        CMD_TOO_LONG: begin
          collecting_nxt = 1'b0;
          emit           = 1'b1;
          verdict_nxt    = V_TOO_LONG;
        end
        CMD_DATA: begin
          held_seq_nxt   = cmd.seq;
          held_len_nxt   = cmd.len;
          held_crc_nxt   = cmd.crc;
          crc_nxt        = CRC_INIT;
          bytes_nxt      = '0;
          collecting_nxt = (cmd.len != '0);
          // empty payload: CRC of nothing, checked at once
          fin_crc        = ~CRC_INIT;
          fin_held_crc   = cmd.crc;
          fin_seq        = cmd.seq;
          if (cmd.len == '0) finish = 1'b1;
        end
        default: ;
      endcase
    end

    // Packet check at the end of the payload
    if (finish) begin
      collecting_nxt = 1'b0;
      emit           = 1'b1;
      ccrc_nxt       = fin_crc;
      priority if (fin_crc != fin_held_crc) begin
        verdict_nxt = V_CRC_BAD;
      end else if (fin_seq == expected_r) begin
        verdict_nxt  = V_ACCEPTED;
        ack_nxt      = 1'b1;
        ack_seq_nxt  = fin_seq;
        expected_nxt = expected_r + 32'd1;
      end else if (expected_r != '0) begin
        verdict_nxt = V_OOO_REACK;
        ack_nxt     = 1'b1;
        ack_seq_nxt = expected_r - 32'd1;
      end else begin
        verdict_nxt = V_OOO_SILENT;
      end
    end

    out_valid_nxt = cmd_ready ? emit : out_valid_r;
  end

  // Receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= '0;
      crc_r        <= CRC_INIT;
      bytes_r      <= '0;
      held_seq_r   <= '0;
      held_len_r   <= '0;
      held_crc_r   <= '0;
      collecting_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      expected_r   <= expected_nxt;
      crc_r        <= crc_nxt;
      bytes_r      <= bytes_nxt;
      held_seq_r   <= held_seq_nxt;
      held_len_r   <= held_len_nxt;
      held_crc_r   <= held_crc_nxt;
      collecting_r <= collecting_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (take && emit) begin
      verdict_r <= verdict_nxt;
      ack_r     <= ack_nxt;
      ack_seq_r <= ack_seq_nxt;
      ccrc_r    <= ccrc_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_ack_valid    = ack_r;
  assign out_ack_sequence = ack_seq_r;
  assign out_computed_crc = ccrc_r;

endmodule

// ===== rtl/core/stop_wait_receiver_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// stop_wait_receiver_crc_check_core: stop-and-wait receiver with CRC-32 check
// An accepted word passes through the command queue and then the result
// register in the execution side before its result word is presented.
// Throughput: one word per cycle, set by the byte-wide CRC update in the
// execution side; a stalled output fills the command queue, then holds input.
// Reset (rst_n, synchronous): expected sequence 0, CRC all ones, queue empty.
// ----------------------------------------------------------------------------
module stop_wait_receiver_crc_check_core
  import swrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_packet_type,
  input  logic [31:0] in_sequence_req,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_sent_crc,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic        out_ack_valid,
  output logic [31:0] out_ack_sequence,
  output logic [31:0] out_computed_crc
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  // Classifier
  swrc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_packet_type    (in_packet_type),
    .in_sequence_req   (in_sequence_req),
    .in_payload_length (in_payload_length),
    .in_sent_crc       (in_sent_crc),
    .in_data_byte      (in_data_byte),
    .cmd_valid         (f_valid),
    .cmd_ready         (f_ready),
    .cmd               (f_cmd)
  );

  // Command queue
  swrc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  // Execution and result register
  swrc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (b_valid),
    .cmd_ready        (b_ready),
    .cmd              (b_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_ack_valid    (out_ack_valid),
    .out_ack_sequence (out_ack_sequence),
    .out_computed_crc (out_computed_crc)
  );

endmodule
